@@ sv/natp_pkg.sv @@
// Shared types and constants of the notification attribute parser.
// Used by the front parser, the request queue, the back serializer and the top level.
package natp_pkg;

  localparam int FIELD_MAX = 256;
  localparam int LIMIT_W = 9;
  localparam logic [LIMIT_W-1:0] LIMIT_CAP =
    (FIELD_MAX < 256) ? LIMIT_W'(FIELD_MAX) : LIMIT_W'(256);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_TERM = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] FIELD_APP = 2'd0;
  localparam logic [1:0] FIELD_TITLE = 2'd1;
  localparam logic [1:0] FIELD_MESSAGE = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_BAD_CMD = 2'd2;
  localparam logic [1:0] ST_TRUNC = 2'd3;

  localparam logic [2:0] REG_CMD = 3'd0;
  localparam logic [2:0] REG_APP_ID = 3'd1;
  localparam logic [2:0] REG_TITLE_ID = 3'd2;
  localparam logic [2:0] REG_MSG_ID = 3'd3;
  localparam logic [2:0] REG_EXP_CNT = 3'd4;
  localparam logic [2:0] REG_APP_LIM = 3'd5;
  localparam logic [2:0] REG_TITLE_LIM = 3'd6;
  localparam logic [2:0] REG_MSG_LIM = 3'd7;

  typedef struct packed {
    logic [7:0] expected_command;
    logic [7:0] app_attribute_id;
    logic [7:0] title_attribute_id;
    logic [7:0] message_attribute_id;
    logic [7:0] expected_attribute_count;
    logic [LIMIT_W-1:0] app_field_limit;
    logic [LIMIT_W-1:0] title_field_limit;
    logic [LIMIT_W-1:0] message_field_limit;
  } cfg_t;

  // At most one request per accepted byte: up to a character, a terminator and a status.
  typedef struct packed {
    logic char_en;
    logic term_en;
    logic stat_en;
    logic [1:0] field;
    logic [7:0] char_pos;
    logic [7:0] char_val;
    logic [7:0] term_pos;
    logic [1:0] status;
    logic [31:0] uid;
    logic [7:0] count;
    logic complete;
  } req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] field;
    logic [7:0] pos;
    logic [7:0] val;
    logic [1:0] status;
    logic [31:0] uid;
    logic [7:0] count;
    logic complete;
    logic last;
  } res_t;

endpackage

@@ sv/natp_front.sv @@
// Front parser: walks the packet byte by byte and turns bytes that yield results into requests.
// Depends on natp_pkg for the configuration and request types.
module natp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  natp_pkg::cfg_t  cfg,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  output logic            req_wr,
  output natp_pkg::req_t  req
);
  import natp_pkg::*;

  localparam logic [2:0] PH_CMD = 3'd0;
  localparam logic [2:0] PH_UID = 3'd1;
  localparam logic [2:0] PH_ID = 3'd2;
  localparam logic [2:0] PH_LLO = 3'd3;
  localparam logic [2:0] PH_LHI = 3'd4;
  localparam logic [2:0] PH_PAY = 3'd5;
  localparam logic [2:0] PH_SKIP = 3'd6;
  localparam logic [2:0] HDR_BYTES = 3'd5;

  logic [2:0]  phase_r, phase_nxt;
  logic [2:0]  hbc_r, hbc_nxt;
  logic [31:0] uid_r, uid_nxt;
  logic [7:0]  attr_r, attr_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic        mism_r, mism_nxt;

  logic              routed;
  logic [1:0]        field;
  logic [LIMIT_W-1:0] lim_raw, lim, lim_m1;
  logic              ch_en, fin, term_en, good;
  logic [4:0]        sh;
  logic [1:0]        status;
  logic [7:0]        term_pos;

  always_comb begin
    routed = 1'b1;
    field = FIELD_APP;
    lim_raw = cfg.app_field_limit;
    if (attr_r == cfg.app_attribute_id) begin
      field = FIELD_APP;
      lim_raw = cfg.app_field_limit;
    end else if (attr_r == cfg.title_attribute_id) begin
      field = FIELD_TITLE;
      lim_raw = cfg.title_field_limit;
    end else if (attr_r == cfg.message_attribute_id) begin
      field = FIELD_MESSAGE;
      lim_raw = cfg.message_field_limit;
    end else begin
      routed = 1'b0;
    end
    lim = (lim_raw > LIMIT_CAP) ? LIMIT_CAP : lim_raw;
    lim_m1 = lim - LIMIT_W'(1);
  end

  always_comb begin
    phase_nxt = phase_r;
    hbc_nxt = hbc_r;
    uid_nxt = uid_r;
    attr_nxt = attr_r;
    len_nxt = len_r;
    pc_nxt = pc_r;
    cnt_nxt = cnt_r;
    mism_nxt = mism_r;
    ch_en = 1'b0;
    fin = 1'b0;
    sh = {hbc_r[1:0] - 2'd1, 3'b000};
    unique case (phase_r)
      PH_CMD: begin
        mism_nxt = (data_byte != cfg.expected_command);
        hbc_nxt = 3'd1;
        phase_nxt = PH_UID;
      end
      PH_UID: begin
        uid_nxt = uid_r | ({24'b0, data_byte} << sh);
        hbc_nxt = hbc_r + 3'd1;
        if (hbc_nxt >= HDR_BYTES) begin
          phase_nxt = mism_r ? PH_SKIP : PH_ID;
        end
      end
      PH_ID: begin
        attr_nxt = data_byte;
        phase_nxt = PH_LLO;
      end
      PH_LLO: begin
        len_nxt = {8'b0, data_byte};
        phase_nxt = PH_LHI;
      end
      PH_LHI: begin
        len_nxt = {data_byte, len_r[7:0]};
        pc_nxt = '0;
        if (len_nxt == 16'd0) begin
          fin = 1'b1;
        end else begin
          phase_nxt = PH_PAY;
        end
      end
      PH_PAY: begin
        ch_en = routed && (lim != '0) && (pc_r < {7'b0, lim_m1});
        pc_nxt = pc_r + 16'd1;
        fin = (pc_nxt == len_r);
      end
      default: begin
      end
    endcase

    term_en = fin && routed && (lim != '0);
    term_pos = (len_nxt < {7'b0, lim_m1}) ? len_nxt[7:0] : lim_m1[7:0];
    if (fin) begin
      if (cnt_r != 8'd255) begin
        cnt_nxt = cnt_r + 8'd1;
      end
      phase_nxt = PH_ID;
    end

    priority if (hbc_nxt < HDR_BYTES) begin
      status = ST_SHORT;
    end else if (mism_nxt) begin
      status = ST_BAD_CMD;
    end else if (phase_nxt == PH_PAY) begin
      status = ST_TRUNC;
    end else begin
      status = ST_OK;
    end
    good = (status == ST_OK) || (status == ST_TRUNC);
  end

  always_comb begin
    req_wr = accept && (ch_en || term_en || last_byte);
    req.char_en = ch_en;
    req.term_en = term_en;
    req.stat_en = last_byte;
    req.field = field;
    req.char_pos = pc_r[7:0];
    req.char_val = data_byte;
    req.term_pos = term_pos;
    req.status = status;
    req.uid = good ? uid_nxt : 32'd0;
    req.count = good ? cnt_nxt : 8'd0;
    req.complete = good && (cfg.expected_attribute_count != 8'd0) &&
                   (cnt_nxt >= cfg.expected_attribute_count);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last_byte)) begin
      phase_r <= PH_CMD;
      hbc_r <= '0;
      uid_r <= '0;
      attr_r <= '0;
      len_r <= '0;
      pc_r <= '0;
      cnt_r <= '0;
      mism_r <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      hbc_r <= hbc_nxt;
      uid_r <= uid_nxt;
      attr_r <= attr_nxt;
      len_r <= len_nxt;
      pc_r <= pc_nxt;
      cnt_r <= cnt_nxt;
      mism_r <= mism_nxt;
    end
  end

  a_hbc_range: assert property (@(posedge clk) disable iff (!rst_n)
    hbc_r <= HDR_BYTES)
    else $error("header byte count out of range");

  a_hdr_before_attr: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ID || phase_r == PH_PAY || phase_r == PH_SKIP) |-> hbc_r == HDR_BYTES)
    else $error("attribute phase entered before the header was complete");

endmodule

@@ sv/natp_queue.sv @@
// Short request queue between the front parser and the back serializer.
// Depends on natp_pkg for the request type and queue depth.
module natp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  natp_pkg::req_t  wr_data,
  input  logic            rd_en,
  output natp_pkg::req_t  rd_data,
  output logic            full,
  output logic            empty
);
  import natp_pkg::*;

  req_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign rd_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_r + QPTR_W'(1);
      end
      if (rd_en) begin
        rp_r <= (rp_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + QCNT_W'(wr_en) - QCNT_W'(rd_en);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && full))
    else $error("request written into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && empty))
    else $error("request read from an empty queue");

endmodule

@@ sv/natp_back.sv @@
// Back serializer: turns each queued request into its results, one per cycle while the output is free or popped.
// Depends on natp_pkg for the request and result types.
module natp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  natp_pkg::req_t  head,
  output logic            q_rd,
  input  logic            pop,
  output logic            empty,
  output natp_pkg::res_t  res
);
  import natp_pkg::*;

  logic [2:0] done_r, done_nxt;
  logic [2:0] rem, sel;
  logic       out_v_r, load;
  res_t       res_r, res_nxt;

  assign rem = {head.stat_en, head.term_en, head.char_en} & ~done_r;
  assign load = !q_empty && (!out_v_r || pop);

  always_comb begin
    res_nxt = '0;
    priority if (rem[0]) begin
      sel = 3'b001;
      res_nxt.kind = KIND_CHAR;
      res_nxt.field = head.field;
      res_nxt.pos = head.char_pos;
      res_nxt.val = head.char_val;
    end else if (rem[1]) begin
      sel = 3'b010;
      res_nxt.kind = KIND_TERM;
      res_nxt.field = head.field;
      res_nxt.pos = head.term_pos;
    end else begin
      sel = 3'b100;
      res_nxt.kind = KIND_STATUS;
      res_nxt.status = head.status;
      res_nxt.uid = head.uid;
      res_nxt.count = head.count;
      res_nxt.complete = head.complete;
      res_nxt.last = 1'b1;
    end
    q_rd = load && ((rem & ~sel) == 3'b000);
    done_nxt = q_rd ? 3'b000 : (done_r | sel);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (load) begin
        done_r <= done_nxt;
      end
      if (load) begin
        out_v_r <= 1'b1;
      end else if (pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign empty = !out_v_r;
  assign res = res_r;

  a_head_not_spent: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> rem != 3'b000)
    else $error("queued request has no result left to send");

endmodule

@@ sv/notification_attribute_tlv_parser.sv @@
// Notification attribute response parser, top level: configuration registers and wiring.
// Instantiates natp_front, natp_queue and natp_back; depends on natp_pkg.
// Takes one byte per cycle while full is low; full rises only when the four-entry
// request queue is full, since one byte can cause up to three results.
// Results pass the queue and output register, then leave one per cycle while pop is high.
// Synchronous reset clears parse state, queue pointers and output valid; restores config.
module notification_attribute_tlv_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_last_byte,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    out_result_kind,
  output logic [1:0]                    out_target_field,
  output logic [7:0]                    out_char_position,
  output logic [7:0]                    out_char_value,
  output logic [1:0]                    out_parse_status,
  output logic [31:0]                   out_notif_uid,
  output logic [7:0]                    out_complete_attributes,
  output logic                          out_response_complete,
  output logic                          out_last_result,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [natp_pkg::LIMIT_W-1:0]  cfg_data
);
  import natp_pkg::*;

  cfg_t cfg_r;
  logic accept, req_wr, q_rd, q_empty;
  req_t req, head;
  res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_command <= 8'd0;
      cfg_r.app_attribute_id <= 8'd0;
      cfg_r.title_attribute_id <= 8'd1;
      cfg_r.message_attribute_id <= 8'd3;
      cfg_r.expected_attribute_count <= 8'd3;
      cfg_r.app_field_limit <= LIMIT_W'(64);
      cfg_r.title_field_limit <= LIMIT_W'(64);
      cfg_r.message_field_limit <= LIMIT_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CMD:       cfg_r.expected_command <= cfg_data[7:0];
        REG_APP_ID:    cfg_r.app_attribute_id <= cfg_data[7:0];
        REG_TITLE_ID:  cfg_r.title_attribute_id <= cfg_data[7:0];
        REG_MSG_ID:    cfg_r.message_attribute_id <= cfg_data[7:0];
        REG_EXP_CNT:   cfg_r.expected_attribute_count <= cfg_data[7:0];
        REG_APP_LIM:   cfg_r.app_field_limit <= cfg_data;
        REG_TITLE_LIM: cfg_r.title_field_limit <= cfg_data;
        REG_MSG_LIM:   cfg_r.message_field_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign accept = push && !full;

  natp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .accept    (accept),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .req_wr    (req_wr),
    .req       (req)
  );

  natp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (req_wr),
    .wr_data (req),
    .rd_en   (q_rd),
    .rd_data (head),
    .full    (full),
    .empty   (q_empty)
  );

  natp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .head    (head),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign out_result_kind = res.kind;
  assign out_target_field = res.field;
  assign out_char_position = res.pos;
  assign out_char_value = res.val;
  assign out_parse_status = res.status;
  assign out_notif_uid = res.uid;
  assign out_complete_attributes = res.count;
  assign out_response_complete = res.complete;
  assign out_last_result = res.last;

endmodule
